[rtl/core/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the buffer slot directory.
// ----------------------------------------------------------------------------
package bsd_pkg;

    // Directory geometry
    localparam int SLOTS      = 32;
    localparam int NUM_BLOCKS = 8192;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int AGE_W  = 6;
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Port field widths
    localparam int OP_W       = 2;
    localparam int BNUM_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int WB_OUT_W   = 13;

    // Widths used to resize internal values onto the port fields
    localparam int SLOT_EXT_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam int WB_EXT_W   = (BLK_W > WB_OUT_W) ? BLK_W : WB_OUT_W;

    // Request operations
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DIRTY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan;
        logic update;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_busy;
    } stat_t;

endpackage

[rtl/core/bsd_ctrl.sv]
// ----------------------------------------------------------------------------
// bsd_ctrl
// Request sequencer: capture, slot scan, state update, result hand-off.
// ----------------------------------------------------------------------------
module bsd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bsd_pkg::stat_t  stat,
    output bsd_pkg::cmd_t   cmd
);

    bsd_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsd_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsd_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.need_scan ? bsd_pkg::S_SCAN : bsd_pkg::S_UPDATE;
                end
            end
            bsd_pkg::S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = bsd_pkg::S_UPDATE;
                end
            end
            bsd_pkg::S_UPDATE: begin
                state_next = bsd_pkg::S_RESP;
            end
            bsd_pkg::S_RESP: begin
                if (!stat.out_busy) begin
                    state_next = bsd_pkg::S_IDLE;
                end
            end
            default: state_next = bsd_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            bsd_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            bsd_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
            end
            bsd_pkg::S_UPDATE: begin
                cmd.update = 1'b1;
            end
            bsd_pkg::S_RESP: begin
                cmd.load_out = !stat.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/bsd_datapath.sv]
// ----------------------------------------------------------------------------
// bsd_datapath
// Slot tables, one-slot-per-cycle scan unit, update logic and result register.
// ----------------------------------------------------------------------------
module bsd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bsd_pkg::cmd_t                      cmd,
    output bsd_pkg::stat_t                     stat,
    input  logic [bsd_pkg::OP_W-1:0]           s_op,
    input  logic [bsd_pkg::BNUM_W-1:0]         s_block_num,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bsd_pkg::STATUS_W-1:0]       m_status,
    output logic [bsd_pkg::SLOT_OUT_W-1:0]     m_slot,
    output logic                               m_writeback_valid,
    output logic [bsd_pkg::WB_OUT_W-1:0]       m_writeback_block
);

    localparam int SLOTS  = bsd_pkg::SLOTS;
    localparam int SLOT_W = bsd_pkg::SLOT_W;
    localparam int CNT_W  = bsd_pkg::CNT_W;
    localparam int BLK_W  = bsd_pkg::BLK_W;
    localparam int AGE_W  = bsd_pkg::AGE_W;

    // Slot state: flags and ages in flops, block numbers in a memory
    logic                   slot_valid_reg [SLOTS];
    logic                   slot_dirty_reg [SLOTS];
    logic [AGE_W-1:0]       slot_age_reg   [SLOTS];
    logic [BLK_W-1:0]       slot_block_mem [SLOTS];

    // Captured request
    logic [bsd_pkg::OP_W-1:0]   op_reg;
    logic [bsd_pkg::BNUM_W-1:0] blk_reg;
    logic                       in_range_reg;

    // Scan: issue counter and read stage
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic               p_vld_reg;
    logic [SLOT_W-1:0]  p_idx_reg;
    logic               p_valid_reg;
    logic               p_dirty_reg;
    logic [AGE_W-1:0]   p_age_reg;
    logic [BLK_W-1:0]   p_block_reg;

    // Scan results
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic               old_found_reg;
    logic [SLOT_W-1:0]  old_idx_reg;
    logic [AGE_W-1:0]   old_age_reg;
    logic               old_dirty_reg;
    logic [BLK_W-1:0]   old_block_reg;
    logic               hit_found_reg;
    logic [SLOT_W-1:0]  hit_idx_reg;

    // Result and output registers
    logic [bsd_pkg::STATUS_W-1:0]   res_status_reg;
    logic [SLOT_W-1:0]              res_slot_reg;
    logic                           res_wbv_reg;
    logic [BLK_W-1:0]               res_wbb_reg;
    logic [bsd_pkg::STATUS_W-1:0]   res_status_next;
    logic [SLOT_W-1:0]              res_slot_next;
    logic                           res_wbv_next;
    logic [BLK_W-1:0]               res_wbb_next;
    logic                           m_valid_reg;
    logic [bsd_pkg::STATUS_W-1:0]   m_status_reg;
    logic [bsd_pkg::SLOT_OUT_W-1:0] m_slot_reg;
    logic                           m_wbv_reg;
    logic [bsd_pkg::WB_OUT_W-1:0]   m_wbb_reg;

    logic                               issue;
    logic [SLOT_W-1:0]                  iss_idx;
    logic                               proc;
    logic [AGE_W-1:0]                   age_inc;
    logic                               take_old;
    logic                               is_hit;
    logic                               s_in_range;
    logic                               do_alloc;
    logic                               do_dirty;
    logic [SLOT_W-1:0]                  pick;
    logic [bsd_pkg::SLOT_EXT_W-1:0]     slot_ext;
    logic [bsd_pkg::WB_EXT_W-1:0]       wbb_ext;

    // Scan control and per-slot compare
    assign issue    = cmd.scan && (iss_cnt_reg != CNT_W'(SLOTS));
    assign iss_idx  = iss_cnt_reg[SLOT_W-1:0];
    assign proc     = cmd.scan && p_vld_reg;
    assign age_inc  = (p_age_reg < bsd_pkg::AGE_MAX) ? p_age_reg + AGE_W'(1) : p_age_reg;
    assign take_old = p_valid_reg && (!old_found_reg || (age_inc > old_age_reg));
    assign is_hit   = p_valid_reg && (p_block_reg == blk_reg[BLK_W-1:0]);

    // Request classification
    assign s_in_range = ({1'b0, s_block_num} < (bsd_pkg::BNUM_W + 1)'(bsd_pkg::NUM_BLOCKS));

    // Update decisions
    assign do_alloc = cmd.update && in_range_reg && (op_reg == bsd_pkg::OP_ALLOC);
    assign do_dirty = cmd.update && in_range_reg && (op_reg == bsd_pkg::OP_DIRTY)
                      && hit_found_reg;
    assign pick     = free_found_reg ? free_idx_reg : old_idx_reg;

    // Status to controller
    assign stat.need_scan = s_in_range && (s_op != bsd_pkg::OP_NONE);
    assign stat.scan_done = (iss_cnt_reg == CNT_W'(SLOTS)) && !p_vld_reg;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // Slot flags, ages and scan control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid_reg[i] <= 1'b0;
                slot_dirty_reg[i] <= 1'b0;
                slot_age_reg[i]   <= '0;
            end
            iss_cnt_reg    <= '0;
            p_vld_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.capture) begin
                iss_cnt_reg    <= '0;
                p_vld_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                old_found_reg  <= 1'b0;
                hit_found_reg  <= 1'b0;
            end
            if (cmd.scan) begin
                p_vld_reg <= issue;
                if (issue) begin
                    iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                end
            end
            // Age occupied slots and track free, oldest and matching slots
            if (proc) begin
                if (op_reg == bsd_pkg::OP_ALLOC) begin
                    if (p_valid_reg) begin
                        slot_age_reg[p_idx_reg] <= age_inc;
                    end else begin
                        free_found_reg <= 1'b1;
                    end
                    if (take_old) begin
                        old_found_reg <= 1'b1;
                    end
                end else if (is_hit) begin
                    hit_found_reg <= 1'b1;
                end
            end
            // Load the chosen slot, or mark the found slot dirty
            if (do_alloc) begin
                slot_valid_reg[pick] <= 1'b1;
                slot_dirty_reg[pick] <= 1'b0;
                slot_age_reg[pick]   <= '0;
            end
            if (do_dirty) begin
                slot_dirty_reg[hit_idx_reg] <= 1'b1;
            end
            // Output handshake
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result of the current request
    always_comb begin
        res_status_next = bsd_pkg::ST_OK;
        res_slot_next   = '0;
        res_wbv_next    = 1'b0;
        res_wbb_next    = '0;
        if (op_reg == bsd_pkg::OP_NONE) begin
            res_status_next = bsd_pkg::ST_OK;
        end else if (!in_range_reg) begin
            res_status_next = bsd_pkg::ST_RANGE;
        end else if (op_reg == bsd_pkg::OP_ALLOC) begin
            res_slot_next = pick;
            if (!free_found_reg && old_dirty_reg) begin
                res_wbv_next = 1'b1;
                res_wbb_next = old_block_reg;
            end
        end else if (hit_found_reg) begin
            res_slot_next = hit_idx_reg;
        end else begin
            res_status_next = bsd_pkg::ST_NOT_FOUND;
        end
    end

    // Payload registers and block memory
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_op;
            blk_reg      <= s_block_num;
            in_range_reg <= s_in_range;
        end
        // Read stage: one slot per cycle
        if (issue) begin
            p_idx_reg   <= iss_idx;
            p_valid_reg <= slot_valid_reg[iss_idx];
            p_dirty_reg <= slot_dirty_reg[iss_idx];
            p_age_reg   <= slot_age_reg[iss_idx];
            p_block_reg <= slot_block_mem[iss_idx];
        end
        if (proc) begin
            if (op_reg == bsd_pkg::OP_ALLOC) begin
                if (!p_valid_reg) begin
                    free_idx_reg <= p_idx_reg;
                end
                if (take_old) begin
                    old_idx_reg   <= p_idx_reg;
                    old_age_reg   <= age_inc;
                    old_dirty_reg <= p_dirty_reg;
                    old_block_reg <= p_block_reg;
                end
            end else if (is_hit && !hit_found_reg) begin
                hit_idx_reg <= p_idx_reg;
            end
        end
        if (do_alloc) begin
            slot_block_mem[pick] <= blk_reg[BLK_W-1:0];
        end
        // Result formation
        if (cmd.update) begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_wbv_reg    <= res_wbv_next;
            res_wbb_reg    <= res_wbb_next;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= slot_ext[bsd_pkg::SLOT_OUT_W-1:0];
            m_wbv_reg    <= res_wbv_reg;
            m_wbb_reg    <= wbb_ext[bsd_pkg::WB_OUT_W-1:0];
        end
    end

    // Resize onto the port fields
    assign slot_ext = bsd_pkg::SLOT_EXT_W'(res_slot_reg);
    assign wbb_ext  = bsd_pkg::WB_EXT_W'(res_wbb_reg);

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_slot            = m_slot_reg;
    assign m_writeback_valid = m_wbv_reg;
    assign m_writeback_block = m_wbb_reg;

endmodule

[rtl/core/buffer_slot_directory.sv]
// ----------------------------------------------------------------------------
// buffer_slot_directory
// Disk block to buffer slot directory with oldest-slot replacement.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Allocate, lookup and mark-dirty
// requests with an in-range block walk all slots through a single read port,
// one slot per cycle, then update the directory in S_UPDATE and load the
// output register in S_RESP. Out-of-range blocks and the unused op code
// skip the walk and go straight to S_UPDATE. The result register lets a new
// request be accepted while the previous result waits for m_ready.
// ----------------------------------------------------------------------------
module buffer_slot_directory (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bsd_pkg::OP_W-1:0]           s_op,
    input  logic [bsd_pkg::BNUM_W-1:0]         s_block_num,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bsd_pkg::STATUS_W-1:0]       m_status,
    output logic [bsd_pkg::SLOT_OUT_W-1:0]     m_slot,
    output logic                               m_writeback_valid,
    output logic [bsd_pkg::WB_OUT_W-1:0]       m_writeback_block
);

    bsd_pkg::cmd_t  cmd;
    bsd_pkg::stat_t stat;

    // Sequencer
    bsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Directory storage and scan datapath
    bsd_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_op              (s_op),
        .s_block_num       (s_block_num),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot            (m_slot),
        .m_writeback_valid (m_writeback_valid),
        .m_writeback_block (m_writeback_block)
    );

endmodule

[dv/buffer_slot_directory_tb.sv]
// ----------------------------------------------------------------------------
// buffer_slot_directory_tb
// Self-checking bench for the buffer slot directory. Requests go in over the
// s_ channel and results come back over the m_ channel. Both sides idle at
// random. A scoreboard keeps its own copy of the slot table, computes the
// expected result of every accepted request and checks each result transfer
// against the oldest expected one.
// ----------------------------------------------------------------------------
module buffer_slot_directory_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bsd_pkg::STATUS_W-1:0]   status;
        logic [bsd_pkg::SLOT_OUT_W-1:0] slot;
        logic                           wb_valid;
        logic [bsd_pkg::WB_OUT_W-1:0]   wb_block;
    } dir_result_t;

    // Slot table copy, expected results and mismatch count
    class slot_directory_scoreboard;
        bit                        held [bsd_pkg::SLOTS];
        bit                        dirty [bsd_pkg::SLOTS];
        logic [bsd_pkg::AGE_W-1:0] age [bsd_pkg::SLOTS];
        logic [bsd_pkg::BLK_W-1:0] blkno [bsd_pkg::SLOTS];
        dir_result_t               expected_results [$];
        int                        mismatches;

        function new();
            for (int i = 0; i < bsd_pkg::SLOTS; i++) begin
                held[i]  = 1'b0;
                dirty[i] = 1'b0;
                age[i]   = '0;
                blkno[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        // Predict the result of one accepted request and update the table
        function void note_request(logic [bsd_pkg::OP_W-1:0] op,
                                   logic [bsd_pkg::BNUM_W-1:0] blk);
            dir_result_t r;
            int          vacant;
            int          oldest;
            int          pick;
            r = '0;
            if (op == bsd_pkg::OP_NONE) begin
                // unused code: no effect, all-zero result
            end else if (blk >= bsd_pkg::NUM_BLOCKS) begin
                r.status = bsd_pkg::ST_RANGE;
            end else if (op == bsd_pkg::OP_ALLOC) begin
                vacant = -1;
                oldest = -1;
                // age occupied slots (saturating), track highest free slot
                for (int i = 0; i < bsd_pkg::SLOTS; i++) begin
                    if (held[i]) begin
                        if (age[i] != bsd_pkg::AGE_MAX)
                            age[i] = age[i] + 1'b1;
                        if (oldest < 0 || age[i] > age[oldest])
                            oldest = i;
                    end else begin
                        vacant = i;
                    end
                end
                if (vacant >= 0) begin
                    pick = vacant;
                end else begin
                    pick = (oldest >= 0) ? oldest : 0;
                    if (dirty[pick]) begin
                        r.wb_valid = 1'b1;
                        r.wb_block = bsd_pkg::WB_OUT_W'(blkno[pick]);
                    end
                end
                held[pick]  = 1'b1;
                dirty[pick] = 1'b0;
                age[pick]   = '0;
                blkno[pick] = bsd_pkg::BLK_W'(blk);
                r.slot      = bsd_pkg::SLOT_OUT_W'(pick);
            end else begin
                // lookup and mark dirty use the lowest matching index
                pick = -1;
                for (int i = 0; i < bsd_pkg::SLOTS && pick < 0; i++)
                    if (held[i] && blkno[i] == bsd_pkg::BLK_W'(blk))
                        pick = i;
                if (pick < 0) begin
                    r.status = bsd_pkg::ST_NOT_FOUND;
                end else begin
                    r.slot = bsd_pkg::SLOT_OUT_W'(pick);
                    if (op == bsd_pkg::OP_DIRTY)
                        dirty[pick] = 1'b1;
                end
            end
            expected_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        task check_result(dir_result_t got);
            dir_result_t exp_r;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d",
                                          got.status, got.slot));
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, exp_r.status));
                if (got.slot !== exp_r.slot)
                    report_mismatch($sformatf("slot got %0d want %0d",
                                              got.slot, exp_r.slot));
                if (got.wb_valid !== exp_r.wb_valid)
                    report_mismatch($sformatf("writeback_valid got %0b want %0b",
                                              got.wb_valid, exp_r.wb_valid));
                if (got.wb_block !== exp_r.wb_block)
                    report_mismatch($sformatf("writeback_block got %0d want %0d",
                                              got.wb_block, exp_r.wb_block));
            end
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [bsd_pkg::OP_W-1:0]       s_op;
    logic [bsd_pkg::BNUM_W-1:0]     s_block_num;
    logic                           m_valid;
    logic                           m_ready;
    logic [bsd_pkg::STATUS_W-1:0]   m_status;
    logic [bsd_pkg::SLOT_OUT_W-1:0] m_slot;
    logic                           m_writeback_valid;
    logic [bsd_pkg::WB_OUT_W-1:0]   m_writeback_block;

    slot_directory_scoreboard  sb = new();
    logic [bsd_pkg::BLK_W-1:0] recent_blocks [$];
    bit                        no_idle;

    buffer_slot_directory dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_block_num       (s_block_num),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot            (m_slot),
        .m_writeback_valid (m_writeback_valid),
        .m_writeback_block (m_writeback_block)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Idle length: mostly none or short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 20);
        else
            return $urandom_range(30, 80);
    endfunction

    // Drive one request; called at a falling edge
    task send_request(logic [bsd_pkg::OP_W-1:0] op, logic [bsd_pkg::BNUM_W-1:0] blk);
        int gap;
        s_op        = op;
        s_block_num = blk;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, blk);
        if (op == bsd_pkg::OP_ALLOC && blk < bsd_pkg::NUM_BLOCKS) begin
            recent_blocks.push_back(bsd_pkg::BLK_W'(blk));
            if (recent_blocks.size() > 48)
                void'(recent_blocks.pop_front());
        end
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // In-range block: mostly recently allocated ones so lookups hit
    function logic [bsd_pkg::BNUM_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && recent_blocks.size() > 0)
            return bsd_pkg::BNUM_W'(recent_blocks[$urandom_range(0, recent_blocks.size() - 1)]);
        else if (r < 80)
            return bsd_pkg::BNUM_W'($urandom_range(0, 47));
        else if (r < 83)
            return bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS - 1);
        else
            return bsd_pkg::BNUM_W'($urandom_range(0, bsd_pkg::NUM_BLOCKS - 1));
    endfunction

    function logic [bsd_pkg::BNUM_W-1:0] pick_bad_block();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS);
        else if (r == 1)
            return {bsd_pkg::BNUM_W{1'b1}};
        else
            return bsd_pkg::BNUM_W'($urandom_range(bsd_pkg::NUM_BLOCKS,
                                                   (1 << bsd_pkg::BNUM_W) - 1));
    endfunction

    // Random op for out-of-range requests
    function logic [bsd_pkg::OP_W-1:0] pick_range_op();
        int k;
        k = $urandom_range(0, 2);
        if (k == 0)
            return bsd_pkg::OP_ALLOC;
        else if (k == 1)
            return bsd_pkg::OP_LOOKUP;
        else
            return bsd_pkg::OP_DIRTY;
    endfunction

    // Result side: random stalls with stretches of constant ready
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 5) == 0) begin
                m_ready = 1'b1;
                repeat ($urandom_range(50, 300)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_ready = 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 5))
                    @(negedge aclk);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(dir_result_t'({m_status, m_slot, m_writeback_valid,
                                           m_writeback_block}));
    end

    // Stimulus and end of run
    initial begin
        int r;
        int tail;
        logic [bsd_pkg::OP_W-1:0] op;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = bsd_pkg::OP_ALLOC;
        s_block_num = '0;
        no_idle     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, every op, misses, duplicates, range errors
        send_request(bsd_pkg::OP_ALLOC,  '0);
        send_request(bsd_pkg::OP_ALLOC,  bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS - 1));
        send_request(bsd_pkg::OP_LOOKUP, '0);
        send_request(bsd_pkg::OP_LOOKUP, bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS - 1));
        send_request(bsd_pkg::OP_LOOKUP, bsd_pkg::BNUM_W'(100));
        send_request(bsd_pkg::OP_DIRTY,  bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS - 1));
        send_request(bsd_pkg::OP_DIRTY,  bsd_pkg::BNUM_W'(100));
        send_request(bsd_pkg::OP_ALLOC,  '0);
        send_request(bsd_pkg::OP_LOOKUP, '0);
        send_request(bsd_pkg::OP_DIRTY,  '0);
        send_request(bsd_pkg::OP_ALLOC,  bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS));
        send_request(bsd_pkg::OP_LOOKUP, bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS));
        send_request(bsd_pkg::OP_DIRTY,  {bsd_pkg::BNUM_W{1'b1}});
        send_request(bsd_pkg::OP_ALLOC,  {bsd_pkg::BNUM_W{1'b1}});
        send_request(bsd_pkg::OP_NONE,   '0);
        send_request(bsd_pkg::OP_NONE,   {bsd_pkg::BNUM_W{1'b1}});
        send_request(bsd_pkg::OP_NONE,   bsd_pkg::BNUM_W'(5));
        send_request(bsd_pkg::OP_LOOKUP, bsd_pkg::BNUM_W'(bsd_pkg::NUM_BLOCKS - 1));
        send_request(bsd_pkg::OP_ALLOC,  bsd_pkg::BNUM_W'(16'h1555));
        send_request(bsd_pkg::OP_ALLOC,  bsd_pkg::BNUM_W'(16'h0AAA));

        // random traffic
        for (int n = 0; n < 650; n++) begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // hold off once until the directory has drained
            if (n == 300) begin
                s_valid = 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 38)
                op = bsd_pkg::OP_ALLOC;
            else if (r < 64)
                op = bsd_pkg::OP_LOOKUP;
            else if (r < 90)
                op = bsd_pkg::OP_DIRTY;
            else if (r < 93)
                op = bsd_pkg::OP_NONE;
            else
                op = pick_range_op();
            if (op == bsd_pkg::OP_NONE)
                send_request(op, bsd_pkg::BNUM_W'($urandom_range(0,
                                                  (1 << bsd_pkg::BNUM_W) - 1)));
            else if (r >= 93)
                send_request(op, pick_bad_block());
            else
                send_request(op, pick_block());
        end
        s_valid = 1'b0;

        // drain, then let the block settle
        while (sb.pending() != 0) @(posedge aclk);
        tail = 0;
        while (tail < 50) begin
            @(posedge aclk);
            tail++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch("expected results left over");
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
